// File: rtl/core/assert_macros.svh
// Assertion macros shared by the checker files of this block.
// Needs nothing but a clock and an active-low reset at the use site.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock, off while reset is low.
`define MERQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Concurrent assertion sampled on the rising clock, also during reset.
`define MERQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// File: rtl/core/merq_pkg.sv
// Shared types, codes and helpers of the mouse event record queue.
// Depends on nothing; the framer, the top level, the checker and the testbench import it.
package merq_pkg;

    localparam int QUEUE_BYTES_DEF = 1024;
    localparam int RECORD_BYTES    = 8;
    localparam int FILL_W          = 11;
    localparam int PADDR_W         = 3;

    typedef logic [1:0] t_req;
    localparam t_req REQ_PS2   = 2'd0;
    localparam t_req REQ_EVENT = 2'd1;
    localparam t_req REQ_READ  = 2'd2;

    typedef logic [2:0] t_status;
    localparam t_status ST_NONE        = 3'd0;
    localparam t_status ST_QUEUED      = 3'd1;
    localparam t_status ST_CLOSED      = 3'd2;
    localparam t_status ST_MOTION_DROP = 3'd3;
    localparam t_status ST_EDGE_DROP   = 3'd4;

    typedef logic [PADDR_W-3:0] t_reg_idx;
    localparam t_reg_idx REG_DEVICE_OPEN  = 1'b0;
    localparam t_reg_idx REG_EDGE_RESERVE = 1'b1;

    localparam logic [9:0] EDGE_RESERVE_RST = 10'd64;
    localparam logic [7:0] PS2_SYNC_MASK    = 8'h08;
    localparam logic [7:0] PS2_BTN_MASK     = 8'h07;
    localparam logic [15:0] SAT_MAX         = 16'h7FFF;
    localparam logic [15:0] SAT_MIN         = 16'h8000;

    typedef struct packed {
        logic        valid;
        logic [7:0]  buttons;
        logic [7:0]  wheel;
        logic [15:0] dx;
        logic [15:0] dy;
        logic [7:0]  hwheel;
    } t_event;

    // Clamp a 32-bit two's complement value to the 16-bit signed range.
    function automatic logic [15:0] sat16(input logic [31:0] x);
        logic [15:0] r;
        if (x[31:15] == {17{x[31]}}) begin
            r = x[15:0];
        end else if (x[31]) begin
            r = SAT_MIN;
        end else begin
            r = SAT_MAX;
        end
        return r;
    endfunction

endpackage

// File: rtl/core/merq_in_if.sv
// Input channel of the mouse event record queue: one request word.
// Depends on nothing.
interface merq_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [7:0]         ps2_byte;
    logic [7:0]         buttons;
    logic signed [7:0]  wheel;
    logic signed [31:0] delta_x;
    logic signed [31:0] delta_y;
    logic signed [7:0]  horiz_wheel;

    modport source (
        output valid, req_type, ps2_byte, buttons, wheel, delta_x, delta_y, horiz_wheel,
        input  ready
    );
    modport sink (
        input  valid, req_type, ps2_byte, buttons, wheel, delta_x, delta_y, horiz_wheel,
        output ready
    );
endinterface

// File: rtl/core/merq_out_if.sv
// Output channel of the mouse event record queue: one result word.
// Depends on nothing.
interface merq_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_status;
    logic [7:0]  read_byte;
    logic        read_valid;
    logic [10:0] queue_fill;
    logic [31:0] motion_drops;
    logic [31:0] edge_drops;

    modport source (
        output valid, event_status, read_byte, read_valid, queue_fill, motion_drops,
               edge_drops,
        input  ready
    );
    modport sink (
        input  valid, event_status, read_byte, read_valid, queue_fill, motion_drops,
               edge_drops,
        output ready
    );
endinterface

// File: rtl/core/merq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module merq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/core/merq_frame.sv
// PS/2 aux packet framer and event normalizer of the mouse event record queue.
// Depends on merq_pkg.
module merq_frame (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  merq_pkg::t_req  i_req_type,
    input  logic [7:0]      i_ps2_byte,
    input  logic [7:0]      i_buttons,
    input  logic [7:0]      i_wheel,
    input  logic [31:0]     i_delta_x,
    input  logic [31:0]     i_delta_y,
    input  logic [7:0]      i_horiz_wheel,
    output merq_pkg::t_event o_event
);
    import merq_pkg::*;

    typedef enum logic [1:0] {
        POS_FIRST,
        POS_SECOND,
        POS_THIRD
    } t_pos;

    t_pos       r_pos;
    logic [7:0] r_first;
    logic [7:0] r_second;

    always_comb begin
        o_event.valid   = 1'b0;
        o_event.buttons = i_buttons;
        o_event.wheel   = i_wheel;
        o_event.dx      = sat16(i_delta_x);
        o_event.dy      = sat16(i_delta_y);
        o_event.hwheel  = i_horiz_wheel;
        unique case (i_req_type)
            REQ_PS2: begin
                o_event.valid   = (r_pos == POS_THIRD);
                o_event.buttons = r_first & PS2_BTN_MASK;
                o_event.wheel   = 8'h00;
                o_event.dx      = {{8{r_second[7]}}, r_second};
                o_event.dy      = {{8{i_ps2_byte[7]}}, i_ps2_byte};
                o_event.hwheel  = 8'h00;
            end
            REQ_EVENT: begin
                o_event.valid = 1'b1;
            end
            default: begin
                o_event.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= POS_FIRST;
            r_first  <= 8'h00;
            r_second <= 8'h00;
        end else if (i_take && (i_req_type == REQ_PS2)) begin
            unique case (r_pos)
                POS_FIRST: begin
                    if ((i_ps2_byte & PS2_SYNC_MASK) != 8'h00) begin
                        r_first <= i_ps2_byte;
                        r_pos   <= POS_SECOND;
                    end
                end
                POS_SECOND: begin
                    r_second <= i_ps2_byte;
                    r_pos    <= POS_THIRD;
                end
                POS_THIRD: begin
                    r_pos <= POS_FIRST;
                end
                default: begin
                    r_pos <= POS_FIRST;
                end
            endcase
        end
    end
endmodule

// File: rtl/core/mouse_event_record_queue.sv
// Mouse event record queue: takes one request word per clock unless the output stalls,
// either a raw PS/2 aux byte, a normalized pointer event or a one-byte read, and returns
// exactly one result word for each. Every request is settled when it is taken and its
// result sits in the output register on the next cycle; a new word is taken in the same
// cycle that the pending result is taken, so the sustained rate is one word per clock.
// The queue is eight byte-wide RAM banks, so a whole 8-byte record is written at once
// and a read pops one byte through the registered read port of its bank. No clearing
// pass runs after reset. QUEUE_BYTES must be a multiple of eight.
// Depends on merq_pkg, merq_in_if, merq_out_if, merq_ram and merq_frame.
module mouse_event_record_queue #(
    parameter int QUEUE_BYTES = merq_pkg::QUEUE_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    merq_in_if.sink                       i_in,
    merq_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [merq_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import merq_pkg::*;

    localparam int ROWS = QUEUE_BYTES / RECORD_BYTES;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int BW   = $clog2(RECORD_BYTES);
    localparam int CW   = $clog2(QUEUE_BYTES + 1);
    localparam int XW   = (CW > FILL_W) ? CW : FILL_W;
    localparam int SW   = XW + 1;

    logic        r_open;
    logic [9:0]  r_reserve;
    logic        cfg_wr;
    t_reg_idx    cfg_idx;

    logic [7:0]    r_last_btn;
    logic [RW-1:0] r_tail;
    logic [RW-1:0] r_head_row;
    logic [BW-1:0] r_head_bank;
    logic [CW-1:0] r_count;
    logic [31:0]   r_mdrops;
    logic [31:0]   r_edrops;

    logic [7:0]    n_last_btn;
    logic [RW-1:0] n_tail;
    logic [RW-1:0] n_head_row;
    logic [BW-1:0] n_head_bank;
    logic [CW-1:0] n_count;
    logic [31:0]   n_mdrops;
    logic [31:0]   n_edrops;

    logic          r_out_valid;
    t_status       r_status;
    logic          r_rd_valid;
    logic [BW-1:0] r_rd_bank;
    logic          n_out_valid;
    t_status       n_status;
    logic          n_rd_valid;

    logic          take;
    t_event        ev;
    logic          is_edge;
    logic [SW-1:0] room;
    logic [SW-1:0] need;
    logic          push;
    logic          pop;
    logic [7:0]    rec    [RECORD_BYTES];
    logic [7:0]    bank_q [RECORD_BYTES];
    logic [XW-1:0] cnt_ext;

    // Configuration port.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[PADDR_W-1:2];

    always_comb begin
        unique case (cfg_idx)
            REG_DEVICE_OPEN:  prdata = {31'd0, r_open};
            REG_EDGE_RESERVE: prdata = {22'd0, r_reserve};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open    <= 1'b0;
            r_reserve <= EDGE_RESERVE_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_DEVICE_OPEN:  r_open    <= pwdata[0];
                REG_EDGE_RESERVE: r_reserve <= pwdata[9:0];
                default:          r_open    <= r_open;
            endcase
        end
    end

    // Handshake.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign take       = i_in.valid && i_in.ready;

    merq_frame u_frame (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_req_type    (i_in.req_type),
        .i_ps2_byte    (i_in.ps2_byte),
        .i_buttons     (i_in.buttons),
        .i_wheel       (i_in.wheel),
        .i_delta_x     (i_in.delta_x),
        .i_delta_y     (i_in.delta_y),
        .i_horiz_wheel (i_in.horiz_wheel),
        .o_event       (ev)
    );

    always_comb begin
        rec[0] = ev.buttons;
        rec[1] = ev.wheel;
        rec[2] = ev.dx[7:0];
        rec[3] = ev.dx[15:8];
        rec[4] = ev.dy[7:0];
        rec[5] = ev.dy[15:8];
        rec[6] = ev.hwheel;
        rec[7] = 8'h00;
    end

    assign is_edge = (ev.buttons != r_last_btn) || (ev.wheel != 8'h00) ||
                     (ev.hwheel != 8'h00);
    assign room    = SW'(QUEUE_BYTES) - SW'(r_count);
    assign need    = is_edge ? SW'(RECORD_BYTES) : (SW'(RECORD_BYTES) + SW'(r_reserve));

    always_comb begin
        n_last_btn  = r_last_btn;
        n_tail      = r_tail;
        n_head_row  = r_head_row;
        n_head_bank = r_head_bank;
        n_count     = r_count;
        n_mdrops    = r_mdrops;
        n_edrops    = r_edrops;
        n_status    = ST_NONE;
        n_rd_valid  = 1'b0;
        push        = 1'b0;
        pop         = 1'b0;
        if (take) begin
            if (ev.valid) begin
                if (!r_open) begin
                    n_status = ST_CLOSED;
                end else if (room >= need) begin
                    push       = 1'b1;
                    n_status   = ST_QUEUED;
                    n_last_btn = ev.buttons;
                    n_count    = r_count + CW'(RECORD_BYTES);
                    n_tail     = (r_tail == RW'(ROWS - 1)) ? '0 : r_tail + 1'b1;
                end else if (is_edge) begin
                    n_status = ST_EDGE_DROP;
                    n_edrops = r_edrops + 32'd1;
                end else begin
                    n_status = ST_MOTION_DROP;
                    n_mdrops = r_mdrops + 32'd1;
                end
            end else if ((i_in.req_type == REQ_READ) && (r_count != '0)) begin
                pop        = 1'b1;
                n_rd_valid = 1'b1;
                n_count    = r_count - 1'b1;
                if (r_head_bank == BW'(RECORD_BYTES - 1)) begin
                    n_head_bank = '0;
                    n_head_row  = (r_head_row == RW'(ROWS - 1)) ? '0 : r_head_row + 1'b1;
                end else begin
                    n_head_bank = r_head_bank + 1'b1;
                end
            end
        end
        n_out_valid = take ? 1'b1 : (o_out.ready ? 1'b0 : r_out_valid);
    end

    for (genvar k = 0; k < RECORD_BYTES; k++) begin : g_bank
        merq_ram #(
            .WIDTH (8),
            .DEPTH (ROWS)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (push),
            .i_waddr (r_tail),
            .i_wdata (rec[k]),
            .i_re    (pop && (r_head_bank == BW'(k))),
            .i_raddr (r_head_row),
            .o_rdata (bank_q[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_btn  <= 8'h00;
            r_tail      <= '0;
            r_head_row  <= '0;
            r_head_bank <= '0;
            r_count     <= '0;
            r_mdrops    <= 32'd0;
            r_edrops    <= 32'd0;
            r_out_valid <= 1'b0;
            r_status    <= ST_NONE;
            r_rd_valid  <= 1'b0;
        end else begin
            r_last_btn  <= n_last_btn;
            r_tail      <= n_tail;
            r_head_row  <= n_head_row;
            r_head_bank <= n_head_bank;
            r_count     <= n_count;
            r_mdrops    <= n_mdrops;
            r_edrops    <= n_edrops;
            r_out_valid <= n_out_valid;
            if (take) begin
                r_status   <= n_status;
                r_rd_valid <= n_rd_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_rd_bank <= r_head_bank;
        end
    end

    // Queue state only moves when a word is taken, so it stays put while a result waits.
    assign cnt_ext             = XW'(r_count);
    assign o_out.valid         = r_out_valid;
    assign o_out.event_status  = r_status;
    assign o_out.read_valid    = r_rd_valid;
    assign o_out.read_byte     = r_rd_valid ? bank_q[r_rd_bank] : 8'h00;
    assign o_out.queue_fill    = cnt_ext[FILL_W-1:0];
    assign o_out.motion_drops  = r_mdrops;
    assign o_out.edge_drops    = r_edrops;
endmodule

// File: rtl/core/merq_checker.sv
// Port-level checker of the mouse event record queue and its bind to the top level.
// Depends on merq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module merq_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_status,
    input logic [7:0] i_read_byte,
    input logic       i_read_valid
);
    import merq_pkg::*;

    property p_read_no_status;
        i_out_valid && i_read_valid |-> i_status == ST_NONE;
    endproperty

    property p_byte_zero;
        i_out_valid && !i_read_valid |-> i_read_byte == 8'h00;
    endproperty

    property p_pass_through;
        i_out_valid && i_out_ready |-> i_in_ready;
    endproperty

    property p_stall_hold;
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_status) && $stable(i_read_byte);
    endproperty

    property p_reset_empty;
        !i_rst_n |=> !i_out_valid;
    endproperty

    // A popped byte only ever comes from a read, which reports no event.
    `MERQ_ASSERT(a_read_no_status, i_clk, i_rst_n, p_read_no_status, "read with event status")
    `MERQ_ASSERT(a_byte_zero, i_clk, i_rst_n, p_byte_zero, "read byte without a popped byte")
    // A result being taken must free the input side in the same cycle.
    `MERQ_ASSERT(a_pass_through, i_clk, i_rst_n, p_pass_through, "input stalled on a taken word")
    `MERQ_ASSERT(a_stall_hold, i_clk, i_rst_n, p_stall_hold, "stalled result word changed")
    `MERQ_ASSERT_ALWAYS(a_reset_empty, i_clk, p_reset_empty, "result word valid after reset")
endmodule

bind mouse_event_record_queue merq_checker u_merq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_status     (o_out.event_status),
    .i_read_byte  (o_out.read_byte),
    .i_read_valid (o_out.read_valid)
);

// File: dv/tb_mouse_event_record_queue.sv
// Testbench of mouse_event_record_queue: directed and random request words with
// register changes between phases; a scoreboard class predicts every result word.
// Depends on merq_pkg, merq_in_if, merq_out_if and the block itself.
module tb_mouse_event_record_queue;
    import merq_pkg::*;

    localparam t_req REQ_UNUSED = 2'd3;

    typedef struct packed {
        t_req               req;
        logic [7:0]         ps2_byte;
        logic [7:0]         buttons;
        logic signed [7:0]  wheel;
        logic signed [31:0] delta_x;
        logic signed [31:0] delta_y;
        logic signed [7:0]  horiz_wheel;
    } t_request;

    typedef struct packed {
        t_status     status;
        logic [7:0]  rbyte;
        logic        rvalid;
        logic [10:0] fill;
        logic [31:0] mdrops;
        logic [31:0] edrops;
    } t_result;

    class record_queue_scoreboard;
        bit        dev_open = 1'b0;
        bit [9:0]  reserve_bytes = EDGE_RESERVE_RST;
        bit [7:0]  first_byte;
        bit [7:0]  second_byte;
        bit [1:0]  frame_pos;
        bit [7:0]  last_buttons;
        bit [7:0]  queued_bytes[$];
        bit [31:0] motion_drops;
        bit [31:0] edge_drops;
        t_result   pending_results[$];
        int        errors;
        int        n_requests;
        int        n_hits;
        int        peak_fill;
        int        status_seen[5];

        function void write_reg(t_reg_idx idx, logic [31:0] val);
            case (idx)
                REG_DEVICE_OPEN: dev_open = val[0];
                REG_EDGE_RESERVE: reserve_bytes = val[9:0];
                default: ;
            endcase
        endfunction

        function logic [15:0] clamp16(logic signed [31:0] v);
            if (v > 32'sd32767) begin
                return SAT_MAX;
            end else if (v < -32'sd32768) begin
                return SAT_MIN;
            end
            return v[15:0];
        endfunction

        function t_status queue_record(logic [7:0] btn, logic [7:0] whl, logic [15:0] dx,
                                       logic [15:0] dy, logic [7:0] hwhl);
            bit is_edge;
            int need;
            int room;
            if (!dev_open) begin
                return ST_CLOSED;
            end
            is_edge = (btn != last_buttons) || (whl != 0) || (hwhl != 0);
            need = RECORD_BYTES + (is_edge ? 0 : int'(reserve_bytes));
            room = QUEUE_BYTES_DEF - queued_bytes.size();
            if (room < need) begin
                if (is_edge) begin
                    edge_drops++;
                    return ST_EDGE_DROP;
                end
                motion_drops++;
                return ST_MOTION_DROP;
            end
            queued_bytes.push_back(btn);
            queued_bytes.push_back(whl);
            queued_bytes.push_back(dx[7:0]);
            queued_bytes.push_back(dx[15:8]);
            queued_bytes.push_back(dy[7:0]);
            queued_bytes.push_back(dy[15:8]);
            queued_bytes.push_back(hwhl);
            queued_bytes.push_back(8'h00);
            last_buttons = btn;
            return ST_QUEUED;
        endfunction

        function void note_request(t_request rq);
            t_result exp;
            exp = '0;
            case (rq.req)
                REQ_PS2: begin
                    if (frame_pos == 2'd0) begin
                        if ((rq.ps2_byte & PS2_SYNC_MASK) != 0) begin
                            first_byte = rq.ps2_byte;
                            frame_pos = 2'd1;
                        end
                    end else if (frame_pos == 2'd1) begin
                        second_byte = rq.ps2_byte;
                        frame_pos = 2'd2;
                    end else begin
                        frame_pos = 2'd0;
                        exp.status = queue_record(first_byte & PS2_BTN_MASK, 8'h00,
                                                  {{8{second_byte[7]}}, second_byte},
                                                  {{8{rq.ps2_byte[7]}}, rq.ps2_byte},
                                                  8'h00);
                    end
                end
                REQ_EVENT: begin
                    exp.status = queue_record(rq.buttons, rq.wheel, clamp16(rq.delta_x),
                                              clamp16(rq.delta_y), rq.horiz_wheel);
                end
                REQ_READ: begin
                    if (queued_bytes.size() > 0) begin
                        exp.rbyte = queued_bytes.pop_front();
                        exp.rvalid = 1'b1;
                        n_hits++;
                    end
                end
                default: ;
            endcase
            exp.fill = 11'(queued_bytes.size());
            exp.mdrops = motion_drops;
            exp.edrops = edge_drops;
            pending_results.push_back(exp);
            n_requests++;
            status_seen[exp.status]++;
            if (queued_bytes.size() > peak_fill) begin
                peak_fill = queued_bytes.size();
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void compare_field(string name, longint exp, longint got);
            if (exp !== got) begin
                errors++;
                $display("%0t: %s expected %0d, got %0d", $time, name, exp, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result exp;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result word with nothing expected, status %0d", $time,
                         got.status);
                return;
            end
            exp = pending_results.pop_front();
            compare_field("event_status", exp.status, got.status);
            compare_field("read_byte", exp.rbyte, got.rbyte);
            compare_field("read_valid", exp.rvalid, got.rvalid);
            compare_field("queue_fill", exp.fill, got.fill);
            compare_field("motion_drops", exp.mdrops, got.mdrops);
            compare_field("edge_drops", exp.edrops, got.edrops);
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_AFTER     = 250;
    localparam int HOLD_CYCLES    = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    merq_in_if  req_if ();
    merq_out_if res_if ();

    record_queue_scoreboard sb;
    bit       tx_eager;
    int       issued;
    bit [7:0] motion_buttons;

    mouse_event_record_queue uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic t_request noise_word(t_req r);
        t_request w;
        w.req = r;
        w.ps2_byte = 8'($urandom);
        w.buttons = 8'($urandom);
        w.wheel = 8'($urandom);
        w.delta_x = $urandom;
        w.delta_y = $urandom;
        w.horiz_wheel = 8'($urandom);
        return w;
    endfunction

    function automatic t_request ps2_word(logic [7:0] b);
        t_request w;
        w = noise_word(REQ_PS2);
        w.ps2_byte = b;
        return w;
    endfunction

    function automatic t_request event_word(logic [7:0] btn, logic [7:0] whl,
                                            logic [31:0] dx, logic [31:0] dy,
                                            logic [7:0] hwhl);
        t_request w;
        w = noise_word(REQ_EVENT);
        w.buttons = btn;
        w.wheel = whl;
        w.delta_x = dx;
        w.delta_y = dy;
        w.horiz_wheel = hwhl;
        return w;
    endfunction

    function automatic logic [31:0] rand_delta();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return int'($urandom_range(0, 1023)) - 512;
        end else if (r < 85) begin
            return ($urandom_range(0, 1) ? 32767 : -32768) + int'($urandom_range(0, 4)) - 2;
        end
        return $urandom;
    endfunction

    task automatic send_word(input t_request rq);
        int gap;
        gap = tx_eager ? 0 : idle_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            req_if.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_if.req_type = rq.req;
        req_if.ps2_byte = rq.ps2_byte;
        req_if.buttons = rq.buttons;
        req_if.wheel = rq.wheel;
        req_if.delta_x = rq.delta_x;
        req_if.delta_y = rq.delta_y;
        req_if.horiz_wheel = rq.horiz_wheel;
        req_if.valid = 1'b1;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sb.note_request(rq);
        issued++;
    endtask

    task automatic settle();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic reg_write(input t_reg_idx idx, input logic [31:0] val);
        logic [31:0] exp_rd;
        exp_rd = (idx == REG_DEVICE_OPEN) ? {31'd0, val[0]} : {22'd0, val[9:0]};
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        sb.compare_field("prdata", exp_rd, prdata);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic run_phase(input int n_words, input int read_pct);
        int start;
        int r;
        int window;
        t_request w;
        start = issued;
        window = 0;
        while (issued - start < n_words) begin
            if (window <= 0) begin
                tx_eager = ($urandom_range(0, 3) == 0);
                window = 40;
            end
            r = $urandom_range(0, 99);
            if (r < read_pct) begin
                send_word(noise_word(REQ_READ));
                window--;
            end else if (r < read_pct + 3) begin
                send_word(noise_word(REQ_UNUSED));
                window--;
            end else if (r < read_pct + 18) begin
                w = ps2_word(8'($urandom));
                if ($urandom_range(0, 9) == 0) begin
                    w.ps2_byte = w.ps2_byte & ~PS2_SYNC_MASK;
                    send_word(w);
                    window--;
                end else begin
                    w.ps2_byte = w.ps2_byte | PS2_SYNC_MASK;
                    send_word(w);
                    send_word(ps2_word(8'($urandom)));
                    send_word(ps2_word(8'($urandom)));
                    window -= 3;
                end
            end else begin
                if ($urandom_range(0, 9) < 3) begin
                    motion_buttons = 8'($urandom);
                end
                w = event_word(motion_buttons, 8'h00, rand_delta(), rand_delta(), 8'h00);
                if ($urandom_range(0, 9) >= 8) begin
                    w.wheel = 8'($urandom);
                end
                if ($urandom_range(0, 9) >= 8) begin
                    w.horiz_wheel = 8'($urandom);
                end
                send_word(w);
                window--;
            end
        end
        settle();
    endtask

    initial begin : result_sink
        int  stall_left;
        int  hold_left;
        int  window;
        int  n_results;
        bit  rx_eager;
        t_result got;
        stall_left = 0;
        hold_left = 0;
        window = 0;
        n_results = 0;
        rx_eager = 1'b0;
        res_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (window == 0) begin
                rx_eager = ($urandom_range(0, 3) == 0);
                window = 64;
            end
            window--;
            if (hold_left > 0) begin
                res_if.ready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                res_if.ready = 1'b0;
                stall_left--;
            end else begin
                res_if.ready = 1'b1;
                if (!rx_eager) begin
                    stall_left = idle_gap();
                end
            end
            @(posedge i_clk);
            if (res_if.valid && res_if.ready) begin
                got.status = res_if.event_status;
                got.rbyte = res_if.read_byte;
                got.rvalid = res_if.read_valid;
                got.fill = res_if.queue_fill;
                got.mdrops = res_if.motion_drops;
                got.edrops = res_if.edge_drops;
                sb.check_result(got);
                n_results++;
                if (n_results == HOLD_AFTER) begin
                    hold_left = HOLD_CYCLES;
                end
            end
        end
    end

    initial begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (i_rst_n !== 1'b1 || (req_if.valid && req_if.ready)
                    || (res_if.valid && res_if.ready)) begin
                stuck = 0;
            end else begin
                stuck++;
            end
        end
        $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        sb = new();
        issued = 0;
        tx_eager = 1'b0;
        motion_buttons = 8'h00;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_if.valid = 1'b0;
        req_if.req_type = REQ_PS2;
        req_if.ps2_byte = '0;
        req_if.buttons = '0;
        req_if.wheel = '0;
        req_if.delta_x = '0;
        req_if.delta_y = '0;
        req_if.horiz_wheel = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // The device starts closed: a full packet is framed but discarded.
        send_word(ps2_word(8'h08));
        send_word(ps2_word(8'h05));
        send_word(ps2_word(8'hFB));
        send_word(noise_word(REQ_READ));
        send_word(event_word(8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF) |
                  {REQ_UNUSED, {($bits(t_request) - 2){1'b0}}});
        settle();
        reg_write(REG_DEVICE_OPEN, 32'd1);
        reg_write(REG_EDGE_RESERVE, 32'd0);

        send_word(ps2_word(8'h00));
        send_word(ps2_word(8'hF7));
        send_word(ps2_word(8'hFF));
        send_word(ps2_word(8'h80));
        send_word(ps2_word(8'h7F));
        send_word(ps2_word(8'h08));
        send_word(ps2_word(8'h7F));
        send_word(ps2_word(8'h80));
        send_word(event_word(8'h00, 8'h00, 32'h8000_0000, 32'h7FFF_FFFF, 8'h00));
        send_word(event_word(8'hFF, 8'h80, 32'd32768, -32'sd32769, 8'h7F));
        send_word(event_word(8'hFF, 8'h7F, -32'sd32768, 32'd32767, 8'h80));
        send_word(event_word(8'hFF, 8'h00, -32'sd1, 32'd1, 8'h00));
        send_word(event_word(8'h00, 8'h00, 32'h7FFF_FFFF, 32'h8000_0000, 8'h01));
        repeat (6) send_word(noise_word(REQ_READ));
        settle();

        run_phase(150, 40);
        reg_write(REG_EDGE_RESERVE, 32'd64);
        run_phase(220, 3);
        run_phase(150, 92);
        reg_write(REG_EDGE_RESERVE, 32'd1016);
        run_phase(140, 45);
        reg_write(REG_EDGE_RESERVE, 32'd1023);
        run_phase(80, 40);
        reg_write(REG_DEVICE_OPEN, 32'd0);
        run_phase(50, 30);
        reg_write(REG_DEVICE_OPEN, 32'd1);
        reg_write(REG_EDGE_RESERVE, $urandom_range(0, 1023));
        run_phase(100, 35);

        repeat (10) @(posedge i_clk);
        $display("Sent %0d words: %0d queued, %0d closed, %0d motion and %0d edge drops.",
                 sb.n_requests, sb.status_seen[ST_QUEUED], sb.status_seen[ST_CLOSED],
                 sb.status_seen[ST_MOTION_DROP], sb.status_seen[ST_EDGE_DROP]);
        $display("%0d reads returned a byte; the queue held at most %0d bytes.",
                 sb.n_hits, sb.peak_fill);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
